/* hdl/fmms_pkg.sv */
// Shared types, constants and helpers for the Fibonacci-modulo set block.
`timescale 1ns / 1ps

package fmms_pkg;

    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;
    localparam int unsigned MUL_STEPS     = 32;

    typedef struct packed {
        logic        kind;
        logic [63:0] index;
    } in_item_t;

    typedef struct packed {
        logic [31:0] fib_value;
        logic        found;
        logic        set_full;
    } out_item_t;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_MUL,
        ST_ADD,
        ST_COMMIT,
        ST_SRD,
        ST_SCMP,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       save_p;
        logic       step;
        logic       add;
        logic       commit;
        logic       sel_acc;
        logic       shift;
        logic       scan_clr;
        logic       rd;
        logic       cmp;
        logic       upd;
        logic       push;
        logic [1:0] entry;
        logic       term;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_bit0;
        logic mm_last;
        logic scan_end;
        logic hit;
        logic out_free;
    } status_t;

    // one conditional subtract: v is known to be below 2*m
    function automatic logic [31:0] reduce_once(input logic [33:0] v, input logic [32:0] m);
        logic [33:0] d;
        d = v - {1'b0, m};
        reduce_once = (v >= {1'b0, m}) ? d[31:0] : v[31:0];
    endfunction

endpackage

/* hdl/fmms_ctrl.sv */
// Sequencer for the Fibonacci-modulo set block: matrix passes and set scan.
`timescale 1ns / 1ps

module fmms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  fmms_pkg::status_t sts,
    output fmms_pkg::cmd_t    cmd
);

    fmms_pkg::state_t state_reg, state_next;
    logic       acc_pass_reg, acc_pass_next;
    logic [1:0] entry_reg, entry_next;
    logic       term_reg, term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fmms_pkg::ST_IDLE;
            acc_pass_reg <= 1'b0;
            entry_reg    <= 2'd0;
            term_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_pass_reg <= acc_pass_next;
            entry_reg    <= entry_next;
            term_reg     <= term_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        acc_pass_next = acc_pass_reg;
        entry_next    = entry_reg;
        term_next     = term_reg;
        unique case (state_reg)
            fmms_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = fmms_pkg::ST_CHECK;
            end
            fmms_pkg::ST_CHECK:
            begin
                entry_next = 2'd0;
                term_next  = 1'b0;
                if (sts.n_zero)
                    state_next = fmms_pkg::ST_SRD;
                else
                begin
                    acc_pass_next = sts.n_bit0;
                    state_next    = fmms_pkg::ST_START;
                end
            end
            fmms_pkg::ST_START:
                state_next = fmms_pkg::ST_MUL;
            fmms_pkg::ST_MUL:
            begin
                if (sts.mm_last)
                begin
                    if (!term_reg)
                    begin
                        term_next  = 1'b1;
                        state_next = fmms_pkg::ST_START;
                    end
                    else
                        state_next = fmms_pkg::ST_ADD;
                end
            end
            fmms_pkg::ST_ADD:
            begin
                term_next  = 1'b0;
                entry_next = entry_reg + 2'd1;
                state_next = (entry_reg == 2'd3) ? fmms_pkg::ST_COMMIT : fmms_pkg::ST_START;
            end
            fmms_pkg::ST_COMMIT:
            begin
                entry_next = 2'd0;
                if (acc_pass_reg)
                begin
                    // follow the accumulate pass with the squaring pass
                    acc_pass_next = 1'b0;
                    state_next    = fmms_pkg::ST_START;
                end
                else
                    state_next = fmms_pkg::ST_CHECK;
            end
            fmms_pkg::ST_SRD:
                state_next = (sts.hit || sts.scan_end) ? fmms_pkg::ST_UPD : fmms_pkg::ST_SCMP;
            fmms_pkg::ST_SCMP:
                state_next = fmms_pkg::ST_SRD;
            fmms_pkg::ST_UPD:
                state_next = fmms_pkg::ST_DONE;
            fmms_pkg::ST_DONE:
            begin
                if (sts.out_free)
                    state_next = fmms_pkg::ST_IDLE;
            end
            default:
                state_next = fmms_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.sel_acc = acc_pass_reg;
        cmd.entry   = entry_reg;
        cmd.term    = term_reg;
        in_stall    = (state_reg != fmms_pkg::ST_IDLE);
        unique case (state_reg)
            fmms_pkg::ST_IDLE:   cmd.load = in_valid;
            fmms_pkg::ST_CHECK:  cmd.scan_clr = sts.n_zero;
            fmms_pkg::ST_START:
            begin
                cmd.start  = 1'b1;
                cmd.save_p = term_reg;
            end
            fmms_pkg::ST_MUL:    cmd.step = 1'b1;
            fmms_pkg::ST_ADD:    cmd.add = 1'b1;
            fmms_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                cmd.shift  = !acc_pass_reg;
            end
            fmms_pkg::ST_SRD:    cmd.rd = !(sts.hit || sts.scan_end);
            fmms_pkg::ST_SCMP:   cmd.cmp = 1'b1;
            fmms_pkg::ST_UPD:    cmd.upd = 1'b1;
            fmms_pkg::ST_DONE:   cmd.push = sts.out_free;
            default:             cmd = '0;
        endcase
    end

endmodule

/* hdl/fmms_dp.sv */
// Datapath: matrix registers, serial modular multiplier, value set and result register.
`timescale 1ns / 1ps

module fmms_dp #(
    parameter int SET_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fmms_pkg::in_item_t  in_data,
    input  logic                cfg_valid,
    input  logic [31:0]         cfg_data,
    input  logic                out_stall,
    output logic                out_valid,
    output fmms_pkg::out_item_t out_data,
    input  fmms_pkg::cmd_t      cmd,
    output fmms_pkg::status_t   sts
);

    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

    logic [31:0] mod_reg;
    logic [63:0] n_reg;
    logic        kind_reg;
    logic [31:0] acc_reg  [4];
    logic [31:0] base_reg [4];
    logic [31:0] tmp_reg  [4];
    logic [31:0] x_reg, y_reg, r_reg, p_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] mem [SET_DEPTH];
    logic [31:0] rd_reg;
    logic [CW-1:0] count_reg, scan_reg;
    logic        hit_reg;
    logic        full_reg;
    logic        out_valid_reg;
    fmms_pkg::out_item_t res_reg;

    logic [32:0] mod_full;
    logic [31:0] init_one;
    logic [1:0]  a_idx, b_idx;
    logic [31:0] a_op, b_op;
    logic [31:0] dbl, r_step, r_add;
    logic [31:0] value;
    logic        room;

    assign mod_full = (mod_reg == 32'd0) ? 33'h1_0000_0000 : {1'b0, mod_reg};
    assign init_one = (mod_reg == 32'd1) ? 32'd0 : 32'd1;
    assign value    = acc_reg[1];
    assign room     = (count_reg < CW'(SET_DEPTH));

    // entry {i,j}, term k: left[i][k] * base[k][j]
    assign a_idx = {cmd.entry[1], cmd.term};
    assign b_idx = {cmd.term, cmd.entry[0]};
    assign a_op  = cmd.sel_acc ? acc_reg[a_idx] : base_reg[a_idx];
    assign b_op  = base_reg[b_idx];

    // interleaved multiply: double, then add x when the top bit of y is set
    assign dbl    = fmms_pkg::reduce_once({1'b0, r_reg, 1'b0}, mod_full);
    assign r_step = fmms_pkg::reduce_once({2'b00, dbl} + (y_reg[31] ? {2'b00, x_reg} : 34'd0),
                                          mod_full);
    assign r_add  = fmms_pkg::reduce_once({2'b00, p_reg} + {2'b00, r_reg}, mod_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg       <= fmms_pkg::MODULUS_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                mod_reg <= cfg_data;
            if (cmd.upd && kind_reg == fmms_pkg::KIND_INSERT && !hit_reg && room)
                count_reg <= count_reg + CW'(1);
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg       <= in_data.index;
            kind_reg    <= in_data.kind;
            acc_reg[0]  <= init_one;
            acc_reg[1]  <= 32'd0;
            acc_reg[2]  <= 32'd0;
            acc_reg[3]  <= init_one;
            base_reg[0] <= init_one;
            base_reg[1] <= init_one;
            base_reg[2] <= init_one;
            base_reg[3] <= 32'd0;
        end
        if (cmd.start)
        begin
            if (cmd.save_p)
                p_reg <= r_reg;
            x_reg   <= a_op;
            y_reg   <= b_op;
            r_reg   <= 32'd0;
            cnt_reg <= 5'd0;
        end
        if (cmd.step)
        begin
            r_reg   <= r_step;
            y_reg   <= {y_reg[30:0], 1'b0};
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (cmd.add)
            tmp_reg[cmd.entry] <= r_add;
        if (cmd.commit)
        begin
            if (cmd.sel_acc)
                acc_reg <= tmp_reg;
            else
                base_reg <= tmp_reg;
        end
        if (cmd.shift)
            n_reg <= {1'b0, n_reg[63:1]};
        if (cmd.load || cmd.scan_clr)
            hit_reg <= 1'b0;
        if (cmd.scan_clr)
            scan_reg <= '0;
        if (cmd.rd)
        begin
            rd_reg   <= mem[scan_reg[AW-1:0]];
            scan_reg <= scan_reg + CW'(1);
        end
        if (cmd.cmp && rd_reg == value)
            hit_reg <= 1'b1;
        if (cmd.upd)
        begin
            if (kind_reg == fmms_pkg::KIND_INSERT && !hit_reg && room)
                mem[count_reg[AW-1:0]] <= value;
            full_reg <= (kind_reg == fmms_pkg::KIND_INSERT) && !hit_reg && !room;
        end
        // load the result only when the output register is free
        if (cmd.push)
        begin
            res_reg.fib_value <= value;
            res_reg.found     <= (kind_reg == fmms_pkg::KIND_QUERY) && hit_reg;
            res_reg.set_full  <= full_reg;
        end
    end

    always_comb
    begin
        sts.n_zero   = (n_reg == 64'd0);
        sts.n_bit0   = n_reg[0];
        sts.mm_last  = (cnt_reg == 5'(fmms_pkg::MUL_STEPS - 1));
        sts.scan_end = (scan_reg >= count_reg);
        sts.hit      = hit_reg;
        sts.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SET_DEPTH))
        else $error("stored count exceeds set depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("stored count moved by more than one");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || !out_stall))
        else $error("result pushed over a held result");

    a_count_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(cmd.upd))
        else $error("stored count changed outside an update");

endmodule

/* hdl/fibonacci_mod_with_membership_set.sv */
// Top level of the Fibonacci-modulo evaluator with membership set.
`timescale 1ns / 1ps

// Takes one request at a time: F(index) mod modulus by matrix square-and-multiply,
// then an insert into or a query of a set of up to SET_DEPTH stored values.
// All products go through one shared bit-serial modular multiplier; a 2x2 matrix
// product is four entries of two products and one modular add each. Each index
// bit up to the highest set one costs a squaring pass, and each set bit an
// accumulate pass before it; then the stored values are scanned up to a hit,
// and the set is updated and the result made. The set needs no clearing after
// reset. A finished result waits in an output register; modulus 0 means 2^32.
module fibonacci_mod_with_membership_set #(
    parameter int SET_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fmms_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output fmms_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    fmms_pkg::cmd_t    cmd;
    fmms_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    fmms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    fmms_dp #(
        .SET_DEPTH (SET_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* dv/tb_fibonacci_mod_with_membership_set.sv */
// Self-checking testbench for the Fibonacci-modulo evaluator with membership set.
`timescale 1ns / 1ps

module tb_fibonacci_mod_with_membership_set;

    localparam int SET_SIZE    = 64;
    localparam int STALL_LIMIT = 200000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    fmms_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    fmms_pkg::out_item_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [31:0]         cfg_data;

    fmms_pkg::in_item_t  pending_reqs[$];
    fmms_pkg::out_item_t expected_results[$];
    logic [31:0] stored_set[$];
    logic [31:0] modulus_now;
    int          mismatches;
    int          idle_cycles;
    int          in_gap;
    int          out_gap;
    bit          calm;

    fibonacci_mod_with_membership_set #(.SET_DEPTH(SET_SIZE)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] mul_mod(logic [31:0] x, logic [31:0] y, logic [31:0] m);
        logic [63:0] p;
        p = {32'd0, x} * {32'd0, y};
        if (m == 32'd0)
            return p[31:0];
        return 32'(p % {32'd0, m});
    endfunction

    function automatic logic [31:0] add_mod(logic [31:0] x, logic [31:0] y, logic [31:0] m);
        logic [63:0] s;
        s = {32'd0, x} + {32'd0, y};
        if (m == 32'd0)
            return s[31:0];
        return 32'(s % {32'd0, m});
    endfunction

    // entries in order [0][0], [0][1], [1][0], [1][1]
    function automatic logic [3:0][31:0] mat_mul(logic [3:0][31:0] a, logic [3:0][31:0] b,
                                                  logic [31:0] m);
        logic [3:0][31:0] c;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                c[i*2+j] = add_mod(mul_mod(a[i*2], b[j], m), mul_mod(a[i*2+1], b[2+j], m), m);
        return c;
    endfunction

    function automatic logic [31:0] fib_mod(logic [63:0] n, logic [31:0] m);
        logic [3:0][31:0] acc;
        logic [3:0][31:0] base;
        acc  = {32'd1, 32'd0, 32'd0, 32'd1};
        base = {32'd0, 32'd1, 32'd1, 32'd1};
        if (m != 32'd0)
            for (int i = 0; i < 4; i++)
            begin
                acc[i]  = acc[i] % m;
                base[i] = base[i] % m;
            end
        while (n != 64'd0)
        begin
            if (n[0])
                acc = mat_mul(acc, base, m);
            base = mat_mul(base, base, m);
            n = n >> 1;
        end
        return acc[1];
    endfunction

    function automatic bit in_stored_set(logic [31:0] v);
        foreach (stored_set[i])
            if (stored_set[i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic predict_result(fmms_pkg::in_item_t req);
        fmms_pkg::out_item_t r;
        r.fib_value = fib_mod(req.index, modulus_now);
        r.found     = 1'b0;
        r.set_full  = 1'b0;
        if (req.kind == fmms_pkg::KIND_INSERT)
        begin
            if (!in_stored_set(r.fib_value))
            begin
                if (stored_set.size() < SET_SIZE)
                    stored_set.push_back(r.fib_value);
                else
                    r.set_full = 1'b1;
            end
        end
        else
            r.found = in_stored_set(r.fib_value);
        expected_results.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // mostly small indices to keep the run short; a few full-width ones
    function automatic logic [63:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return {$urandom, $urandom};
        if (r < 14)
            return 64'($urandom_range(0, 4095));
        return 64'($urandom_range(0, 24));
    endfunction

    task automatic add_request(logic kind, logic [63:0] index);
        fmms_pkg::in_item_t req;
        req.kind  = kind;
        req.index = index;
        pending_reqs.push_back(req);
    endtask

    task automatic add_random(int count);
        logic [63:0] idx;
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            idx = pick_index();
            if (r < 45)
            begin
                // insert followed by a query that usually hits
                add_request(fmms_pkg::KIND_INSERT, idx);
                add_request(fmms_pkg::KIND_QUERY,
                            ($urandom_range(0, 3) != 0) ? idx : pick_index());
                k++;
            end
            else
                add_request(logic'($urandom_range(0, 1)), idx);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_modulus(logic [31:0] value);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        modulus_now = value;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                    predict_result(in_data);
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    in_gap   <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        fmms_pkg::out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: fib_value=%0d found=%0b set_full=%0b",
                                 out_data.fib_value, out_data.found, out_data.set_full);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want != out_data)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     want.fib_value, want.found, want.set_full,
                                     out_data.fib_value, out_data.found, out_data.set_full);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_gap   <= pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_gap      = 0;
        out_gap     = 0;
        idle_cycles = 0;
        mismatches  = 0;
        calm        = 1'b0;
        modulus_now = fmms_pkg::MODULUS_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, duplicates, query miss and hit
        add_request(fmms_pkg::KIND_QUERY, 64'd0);
        add_request(fmms_pkg::KIND_INSERT, 64'd0);
        add_request(fmms_pkg::KIND_INSERT, 64'd0);
        add_request(fmms_pkg::KIND_QUERY, 64'd0);
        add_request(fmms_pkg::KIND_INSERT, 64'd1);
        add_request(fmms_pkg::KIND_INSERT, 64'd2);
        add_request(fmms_pkg::KIND_QUERY, 64'd2);
        add_request(fmms_pkg::KIND_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(fmms_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(fmms_pkg::KIND_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(fmms_pkg::KIND_INSERT, 64'h8000_0000_0000_0000);
        add_request(fmms_pkg::KIND_INSERT, 64'h5555_5555_5555_5555);
        add_request(fmms_pkg::KIND_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
        add_request(fmms_pkg::KIND_QUERY, 64'd90);
        calm = 1'b1;
        add_random(120);
        wait_drained();
        calm = 1'b0;
        add_random(180);

        // small modulus: many duplicates
        write_modulus(32'd7);
        add_random(180);

        // modulus one: every value is zero
        write_modulus(32'd1);
        add_request(fmms_pkg::KIND_INSERT, 64'd5);
        add_request(fmms_pkg::KIND_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        add_random(80);

        // modulus zero wraps at 2^32; distinct indices fill the set
        write_modulus(32'd0);
        for (int i = 3; i < 96; i++)
            add_request(fmms_pkg::KIND_INSERT, 64'(i));
        add_request(fmms_pkg::KIND_QUERY, 64'd50);
        add_request(fmms_pkg::KIND_QUERY, 64'd200);
        add_request(fmms_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        add_random(150);

        // largest modulus
        write_modulus(32'hFFFF_FFFF);
        add_random(160);

        write_modulus(32'd2);
        add_random(60);

        write_modulus(fmms_pkg::MODULUS_RESET);
        add_random(130);

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* fibonacci_mod_with_membership_set.f */
hdl/fmms_pkg.sv
hdl/fmms_ctrl.sv
hdl/fmms_dp.sv
hdl/fibonacci_mod_with_membership_set.sv
dv/tb_fibonacci_mod_with_membership_set.sv
